// ===== rtl/gmpv_pkg.sv =====
// Shared constants, codes, types and helpers of the GF(2) product verifier.
package gmpv_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 256;

   localparam int unsigned DATA_W   = 64;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned ROW_W    = 8;
   localparam int unsigned WIDX_W   = 2;
   localparam int unsigned DIM_W    = 9;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   // last bit lane of a 64-bit word
   localparam logic [5:0] LANE_LAST = 6'd63;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_A = 3'd0,
      ACT_LOAD_B = 3'd1,
      ACT_LOAD_C = 3'd2,
      ACT_LOAD_P = 3'd3,
      ACT_CHECK  = 3'd4
   } action_type;

   // region of the matrix memory
   typedef enum logic [1:0] {
      MAT_A = 2'd0,
      MAT_B = 2'd1,
      MAT_C = 2'd2
   } matrix_type;

   // region of the vector memory
   typedef enum logic {
      VEC_PROBE = 1'b0,
      VEC_INTER = 1'b1
   } vector_type;

   typedef struct packed {
      logic done;
      logic match;
      logic zero_probe;
   } result_type;

   // columns of word w that lie below size n
   function automatic logic [DATA_W-1:0] word_mask(input logic [31:0] w, input logic [31:0] n);
      logic [31:0]       hi;
      logic [DATA_W-1:0] m;
      hi = n >> 6;
      if (w < hi) begin
         m = '1;
      end else if (w == hi) begin
         m = (DATA_W'(1) << n[5:0]) - DATA_W'(1);
      end else begin
         m = '0;
      end
      return m;
   endfunction

endpackage

// ===== rtl/gmpv_ifs.sv =====
// Channel interfaces: request, response and register write.
interface gmpv_req_if
   import gmpv_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ROW_W-1:0]    row;
   logic [WIDX_W-1:0]   word_index;
   logic [DATA_W-1:0]   data_word;

   modport source (output valid, action, row, word_index, data_word, input ready);
   modport sink   (input valid, action, row, word_index, data_word, output ready);
endinterface

interface gmpv_rsp_if;
   logic valid;
   logic ready;
   logic match;
   logic zero_probe;

   modport source (output valid, match, zero_probe, input ready);
   modport sink   (input valid, match, zero_probe, output ready);
endinterface

interface gmpv_csr_if
   import gmpv_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [DIM_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/gf2_matrix_product_verifier_core.sv =====
// Top level of the GF(2) matrix product verifier (Freivalds check).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  req_ch  | in  | valid/ready        | action, row, word_index, data_word
//  rsp_ch  | out | valid/ready        | match, zero_probe
//  csr_ch  | in  | valid/ready (rdy=1)| data = dim
//
//  Loads (A, B, C row words, probe words) are taken one per cycle, back to
//  back, while no check runs. A check runs a probe scan, then a pass for
//  t = B.r and a combined A.t / C.r pass, paced by the single read port
//  of the matrix memory. An all-zero probe finishes after the scan.
//  Reset clears control state and the probe word valid bits; there is no
//  clearing pass. Matrix rows read as undefined until loaded.
//  req_ch stalls while a check runs, and a new check waits while a result
//  transaction is still pending on rsp_ch; loads keep flowing meanwhile.
module gf2_matrix_product_verifier_core
   import gmpv_pkg::*;
#(
   parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   gmpv_req_if.sink   req_ch,
   gmpv_rsp_if.source rsp_ch,
   gmpv_csr_if.sink   csr_ch
);

   localparam int unsigned WORDS    = (MAX_DIM + 63) / 64;
   localparam int unsigned WB       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned WP       = 1 << WB;
   localparam int unsigned ROW_BITS = $clog2(MAX_DIM);
   localparam int unsigned MAW      = 2 + ROW_BITS + WB;
   localparam int unsigned VAW      = 1 + WB;

   // configuration and status
   logic [DIM_W-1:0] dim_ff;
   logic [WP-1:0]    probe_vld_ff;
   logic             rsp_valid_ff, rsp_match_ff, rsp_zero_ff;

   // request decode
   logic       req_acc, row_ok, widx_ok, chk_req;
   logic       mat_load, probe_load;
   matrix_type mat_sel;

   // memory ports
   logic              m_we;
   logic [MAW-1:0]    m_waddr, m_raddr;
   logic [DATA_W-1:0] m_rdata;
   logic              v_we, eng_v_we;
   logic [VAW-1:0]    v_waddr, v_raddr, eng_v_waddr;
   logic [DATA_W-1:0] v_wdata, v_rdata, eng_v_wdata;

   logic       eng_idle;
   result_type eng_res;

   assign chk_req      = (req_ch.action == ACT_CHECK);
   // loads pass while a result waits; a check needs the result slot free
   assign req_ch.ready = eng_idle && !(rsp_valid_ff && chk_req);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign row_ok       = (32'(req_ch.row) < MAX_DIM);
   assign widx_ok      = (32'(req_ch.word_index) < WORDS);

   always_comb begin
      mat_load   = 1'b0;
      probe_load = 1'b0;
      mat_sel    = MAT_A;
      unique case (req_ch.action)
         ACT_LOAD_A: begin
            mat_load = 1'b1;
            mat_sel  = MAT_A;
         end
         ACT_LOAD_B: begin
            mat_load = 1'b1;
            mat_sel  = MAT_B;
         end
         ACT_LOAD_C: begin
            mat_load = 1'b1;
            mat_sel  = MAT_C;
         end
         ACT_LOAD_P: begin
            probe_load = 1'b1;
         end
         default: begin
            mat_load   = 1'b0;
            probe_load = 1'b0;
         end
      endcase
   end

   // matrix memory: {region, row, word}
   assign m_we    = req_acc && mat_load && row_ok && widx_ok;
   assign m_waddr = {mat_sel, ROW_BITS'(req_ch.row), WB'(req_ch.word_index)};

   gmpv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (1 << MAW)
   ) u_mat_ram (
      .clock (clock),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (req_ch.data_word),
      .raddr (m_raddr),
      .rdata (m_rdata)
   );

   // vector memory: probe words and t words; the engine writes only while busy
   assign v_we    = eng_v_we || (req_acc && probe_load && widx_ok);
   assign v_waddr = eng_v_we ? eng_v_waddr : {VEC_PROBE, WB'(req_ch.word_index)};
   assign v_wdata = eng_v_we ? eng_v_wdata : req_ch.data_word;

   gmpv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (1 << VAW)
   ) u_vec_ram (
      .clock (clock),
      .we    (v_we),
      .waddr (v_waddr),
      .wdata (v_wdata),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   gmpv_engine #(
      .MAX_DIM (MAX_DIM)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start_i     (req_acc && chk_req),
      .dim_i       (dim_ff),
      .probe_vld_i (probe_vld_ff),
      .m_raddr_o   (m_raddr),
      .m_rdata_i   (m_rdata),
      .v_raddr_o   (v_raddr),
      .v_rdata_i   (v_rdata),
      .v_we_o      (eng_v_we),
      .v_waddr_o   (eng_v_waddr),
      .v_wdata_o   (eng_v_wdata),
      .idle_o      (eng_idle),
      .res_o       (eng_res)
   );

   assign csr_ch.ready = 1'b1;

   // probe words never loaded read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= DIM_RESET;
         probe_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            dim_ff <= csr_ch.data;
         end
         if (req_acc && probe_load && widx_ok) begin
            probe_vld_ff[WB'(req_ch.word_index)] <= 1'b1;
         end
         if (eng_res.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res.done) begin
         rsp_match_ff <= eng_res.match;
         rsp_zero_ff  <= eng_res.zero_probe;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.match      = rsp_match_ff;
   assign rsp_ch.zero_probe = rsp_zero_ff;

   a_check_needs_free_slot: assert property (@(posedge clock) disable iff (reset)
      (req_acc && chk_req) |-> !rsp_valid_ff)
      else $error("check accepted while a result is pending");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      eng_res.done |-> !rsp_valid_ff)
      else $error("result overwrites a pending transaction");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      m_we |-> eng_idle)
      else $error("matrix load while a check runs");

endmodule

// ===== rtl/gmpv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gmpv_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/gmpv_engine.sv =====
// Check sequencer: probe scan, t = B.r pass, combined A.t / C.r pass.
module gmpv_engine
   import gmpv_pkg::*;
#(
   parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start_i,
   input  logic [DIM_W-1:0] dim_i,
   input  logic [((((MAX_DIM + 63) / 64) > 1) ? (1 << $clog2((MAX_DIM + 63) / 64)) : 2)-1:0]
                probe_vld_i,
   output logic [2 + $clog2(MAX_DIM)
                 + ((((MAX_DIM + 63) / 64) > 1) ? $clog2((MAX_DIM + 63) / 64) : 1)-1:0]
                m_raddr_o,
   input  logic [DATA_W-1:0] m_rdata_i,
   output logic [((((MAX_DIM + 63) / 64) > 1) ? $clog2((MAX_DIM + 63) / 64) : 1):0]
                v_raddr_o,
   input  logic [DATA_W-1:0] v_rdata_i,
   output logic v_we_o,
   output logic [((((MAX_DIM + 63) / 64) > 1) ? $clog2((MAX_DIM + 63) / 64) : 1):0]
                v_waddr_o,
   output logic [DATA_W-1:0] v_wdata_o,
   output logic idle_o,
   output result_type res_o
);

   localparam int unsigned WORDS    = (MAX_DIM + 63) / 64;
   localparam int unsigned WB       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned KB       = WB + 1;
   localparam int unsigned ROW_BITS = $clog2(MAX_DIM);
   localparam int unsigned NB       = $clog2(MAX_DIM + 1);
   localparam logic [KB-1:0] K_LAST_B = KB'(WORDS - 1);
   localparam logic [KB-1:0] K_LAST_A = KB'(2 * WORDS - 1);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_SCAN      = 7'b0000010,
      S_SCAN_END  = 7'b0000100,
      S_BPASS     = 7'b0001000,
      S_BPASS_END = 7'b0010000,
      S_APASS     = 7'b0100000,
      S_APASS_END = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [KB-1:0]       k_ff, k_in;
   logic [NB-1:0]       n_ff, n_in;
   logic [ROW_BITS-1:0] nm1_ff, nm1_in;
   // data stage: tags of the words returning from both memories
   logic                d_valid_ff, d_valid_in;
   logic [WB-1:0]       d_word_ff, d_word_in;
   logic                d_probe_ff, d_probe_in;
   logic                d_end_ff, d_end_in;
   logic                d_last_ff, d_last_in;
   logic [ROW_BITS-1:0] d_row_ff, d_row_in;
   logic                par_ff, par_in;
   logic                any_ff, any_in;
   logic                mism_ff, mism_in;
   logic [DATA_W-1:0]   tword_ff, tword_in;

   logic [NB-1:0]     n_sel;
   logic [DATA_W-1:0] vec_raw, vec_val, term, tw_x;
   logic              par_x, any_x, mism_x;
   logic              scan_ph, b_ph, a_ph, row_done, t_wr;
   logic [5:0]        row_lo6;

   always_comb begin
      if (dim_i == '0) begin
         n_sel = NB'(1);
      end else if (32'(dim_i) > MAX_DIM) begin
         n_sel = NB'(MAX_DIM);
      end else begin
         n_sel = NB'(dim_i);
      end
   end

   // data stage
   assign scan_ph = (state_ff == S_SCAN)  || (state_ff == S_SCAN_END);
   assign b_ph    = (state_ff == S_BPASS) || (state_ff == S_BPASS_END);
   assign a_ph    = (state_ff == S_APASS) || (state_ff == S_APASS_END);

   assign vec_raw  = v_rdata_i & word_mask(32'(d_word_ff), 32'(n_ff));
   assign vec_val  = (d_probe_ff && !probe_vld_i[d_word_ff]) ? '0 : vec_raw;
   assign term     = m_rdata_i & vec_val;
   assign par_x    = par_ff ^ (^term);
   assign any_x    = any_ff | (d_valid_ff && scan_ph && (|vec_val));
   assign row_done = d_valid_ff && d_end_ff;
   assign mism_x   = mism_ff | (row_done && a_ph && par_x);
   assign row_lo6  = 6'(d_row_ff);
   assign tw_x     = tword_ff | (DATA_W'(par_x) << row_lo6);
   assign t_wr     = row_done && b_ph && ((row_lo6 == LANE_LAST) || d_last_ff);

   assign v_we_o    = t_wr;
   assign v_waddr_o = {VEC_INTER, WB'(d_row_ff >> 6)};
   assign v_wdata_o = tw_x;
   assign idle_o    = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      nm1_in     = nm1_ff;
      d_valid_in = 1'b0;
      d_word_in  = d_word_ff;
      d_probe_in = d_probe_ff;
      d_end_in   = 1'b0;
      d_last_in  = 1'b0;
      d_row_in   = row_ff;
      any_in     = any_x;
      mism_in    = mism_x;
      par_in     = par_ff;
      tword_in   = tword_ff;
      m_raddr_o  = {MAT_A, row_ff, k_ff[WB-1:0]};
      v_raddr_o  = {VEC_PROBE, k_ff[WB-1:0]};
      res_o      = '0;

      if (d_valid_ff && (b_ph || a_ph)) begin
         par_in = d_end_ff ? 1'b0 : par_x;
      end
      if (t_wr) begin
         tword_in = '0;
      end else if (row_done && b_ph) begin
         tword_in = tw_x;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               n_in     = n_sel;
               nm1_in   = ROW_BITS'(n_sel - NB'(1));
               k_in     = '0;
               any_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            d_valid_in = 1'b1;
            d_word_in  = k_ff[WB-1:0];
            d_probe_in = 1'b1;
            if (k_ff == K_LAST_B) begin
               k_in     = '0;
               state_in = S_SCAN_END;
            end else begin
               k_in = k_ff + KB'(1);
            end
         end
         S_SCAN_END: begin
            if (!any_x) begin
               res_o    = '{done: 1'b1, match: 1'b0, zero_probe: 1'b1};
               state_in = S_IDLE;
            end else begin
               row_in   = '0;
               par_in   = 1'b0;
               tword_in = '0;
               state_in = S_BPASS;
            end
         end
         S_BPASS: begin
            m_raddr_o  = {MAT_B, row_ff, k_ff[WB-1:0]};
            v_raddr_o  = {VEC_PROBE, k_ff[WB-1:0]};
            d_valid_in = 1'b1;
            d_word_in  = k_ff[WB-1:0];
            d_probe_in = 1'b1;
            d_end_in   = (k_ff == K_LAST_B);
            d_last_in  = (row_ff == nm1_ff);
            if (k_ff == K_LAST_B) begin
               k_in = '0;
               if (row_ff == nm1_ff) begin
                  state_in = S_BPASS_END;
               end else begin
                  row_in = row_ff + ROW_BITS'(1);
               end
            end else begin
               k_in = k_ff + KB'(1);
            end
         end
         S_BPASS_END: begin
            row_in   = '0;
            mism_in  = 1'b0;
            par_in   = 1'b0;
            state_in = S_APASS;
         end
         S_APASS: begin
            // even steps: A row with t, odd steps: C row with r
            if (k_ff[0]) begin
               m_raddr_o = {MAT_C, row_ff, k_ff[KB-1:1]};
               v_raddr_o = {VEC_PROBE, k_ff[KB-1:1]};
            end else begin
               m_raddr_o = {MAT_A, row_ff, k_ff[KB-1:1]};
               v_raddr_o = {VEC_INTER, k_ff[KB-1:1]};
            end
            d_valid_in = 1'b1;
            d_word_in  = k_ff[KB-1:1];
            d_probe_in = k_ff[0];
            d_end_in   = (k_ff == K_LAST_A);
            d_last_in  = (row_ff == nm1_ff);
            if (k_ff == K_LAST_A) begin
               k_in = '0;
               if (row_ff == nm1_ff) begin
                  state_in = S_APASS_END;
               end else begin
                  row_in = row_ff + ROW_BITS'(1);
               end
            end else begin
               k_in = k_ff + KB'(1);
            end
         end
         S_APASS_END: begin
            res_o    = '{done: 1'b1, match: !mism_x, zero_probe: 1'b0};
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         d_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         d_valid_ff <= d_valid_in;
      end
      row_ff     <= row_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      nm1_ff     <= nm1_in;
      d_word_ff  <= d_word_in;
      d_probe_ff <= d_probe_in;
      d_end_ff   <= d_end_in;
      d_last_ff  <= d_last_in;
      d_row_ff   <= d_row_in;
      par_ff     <= par_in;
      any_ff     <= any_in;
      mism_ff    <= mism_in;
      tword_ff   <= tword_in;
   end

   a_inter_wr_in_bpass: assert property (@(posedge clock) disable iff (reset)
      v_we_o |-> (state_ff == S_BPASS || state_ff == S_BPASS_END))
      else $error("t word written outside the B pass");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      res_o.done |-> !(res_o.match && res_o.zero_probe))
      else $error("match reported with a zero probe");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BPASS || state_ff == S_APASS) |-> (row_ff <= nm1_ff))
      else $error("row counter beyond size");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !d_valid_ff)
      else $error("read data in flight while idle");

endmodule
